// File: sv/mmt_pkg.sv
// ============================================================================
// mmt_pkg
// Shared types and codes for the message match table: request and status
// codes, the chain record passed from cell to cell, and the commit controls.
// ============================================================================
package mmt_pkg;

   localparam int TAG_BITS       = 16;
   localparam int NODE_PORT_BITS = 10;
   localparam int SIZE_BITS      = 32;
   localparam int DATA_BITS      = 64;
   localparam int FUNC_BITS      = 3;
   localparam int STATUS_BITS    = 3;

   // request codes; codes above POP_RECV behave as a lookup
   localparam logic [FUNC_BITS-1:0] FUNC_INS_SEND = 3'd0;
   localparam logic [FUNC_BITS-1:0] FUNC_INS_RECV = 3'd1;
   localparam logic [FUNC_BITS-1:0] FUNC_LOOKUP   = 3'd2;
   localparam logic [FUNC_BITS-1:0] FUNC_POP_SEND = 3'd3;
   localparam logic [FUNC_BITS-1:0] FUNC_POP_RECV = 3'd4;

   localparam logic [STATUS_BITS-1:0] STAT_OK        = 3'd0;
   localparam logic [STATUS_BITS-1:0] STAT_NOT_FOUND = 3'd1;
   localparam logic [STATUS_BITS-1:0] STAT_MISMATCH  = 3'd2;
   localparam logic [STATUS_BITS-1:0] STAT_DUPLICATE = 3'd3;
   localparam logic [STATUS_BITS-1:0] STAT_FULL      = 3'd4;

   typedef enum logic {
      MMT_IDLE,
      MMT_SCAN
   } mmt_state_type;

   // record that walks down the cell row, one cell per cycle
   typedef struct packed {
      logic                 token;
      logic                 hit;
      logic                 hit_send;
      logic                 free_seen;
      logic [DATA_BITS-1:0] payload;
   } mmt_chain_type;

   // broadcast to all cells in the cycle that closes a scan
   typedef struct packed {
      logic do_insert;
      logic do_pop;
      logic is_send;
   } mmt_commit_type;

endpackage

// File: sv/mmt_cell.sv
// ============================================================================
// mmt_cell
// One table slot. Compares the held request key when the scan token passes,
// forwards the running hit / free record to the next cell, and remembers
// whether it is the matching slot or the first free slot for the commit.
// ============================================================================
module mmt_cell #(
   parameter int ROUTE_BITS = 36
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic [ROUTE_BITS-1:0]           req_route,
   input  logic [mmt_pkg::SIZE_BITS-1:0]   req_size,
   input  logic [mmt_pkg::DATA_BITS-1:0]   req_data,
   input  mmt_pkg::mmt_commit_type         commit,
   input  mmt_pkg::mmt_chain_type          chain_in,
   output mmt_pkg::mmt_chain_type          chain_out
);

   logic                          valid_ff;
   logic                          is_send_ff;
   logic [ROUTE_BITS-1:0]         route_ff;
   logic [mmt_pkg::SIZE_BITS-1:0] size_ff;
   logic [mmt_pkg::DATA_BITS-1:0] payload_ff;
   logic                          mark_match_ff;
   logic                          mark_free_ff;
   mmt_pkg::mmt_chain_type        chain_ff;
   mmt_pkg::mmt_chain_type        chain_in_c;
   logic                          match;

   assign match = valid_ff && (route_ff == req_route) && (size_ff == req_size);

   always_comb begin
      chain_in_c = chain_in;
      if (chain_in.token) begin
         if (match) begin
            chain_in_c.hit      = 1'b1;
            chain_in_c.hit_send = is_send_ff;
            chain_in_c.payload  = payload_ff;
         end
         if (!valid_ff) begin
            chain_in_c.free_seen = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         chain_ff      <= '0;
         valid_ff      <= 1'b0;
         mark_match_ff <= 1'b0;
         mark_free_ff  <= 1'b0;
      end else begin
         chain_ff <= chain_in_c;
         if (chain_in.token) begin
            mark_match_ff <= match;
            mark_free_ff  <= !valid_ff && !chain_in.free_seen;
         end
         if (commit.do_pop && mark_match_ff) begin
            valid_ff <= 1'b0;
         end
         if (commit.do_insert && mark_free_ff) begin
            valid_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (commit.do_insert && mark_free_ff) begin
         is_send_ff <= commit.is_send;
         route_ff   <= req_route;
         size_ff    <= req_size;
         payload_ff <= req_data;
      end
   end

   assign chain_out = chain_ff;

endmodule

// File: sv/message_match_table_unit.sv
// ============================================================================
// message_match_table_unit
// Exact-match table of pending send / recv messages keyed by tag, source,
// destination and byte count, built as a row of slot cells.
// ============================================================================
//
//   channel   ports                       handshake
//   -------   -------------------------   ------------------------------
//   request   req_*, start, busy          taken when start & !busy
//   response  rsp_*, rsp_strobe           one cycle, cannot be held off
//
// An item runs through a capture cycle, the scan token walking the row one
// cell per cycle, and a commit cycle. The response strobe comes in the cycle
// busy falls. Reset empties the table; there is no clearing pass.
//
module message_match_table_unit #(
   parameter int TABLE_DEPTH  = 64,
   parameter int NODE_ID_BITS = 10
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic [mmt_pkg::FUNC_BITS-1:0]       req_func,
   input  logic [mmt_pkg::TAG_BITS-1:0]        req_msg_tag,
   input  logic [mmt_pkg::NODE_PORT_BITS-1:0]  req_src_node,
   input  logic [mmt_pkg::NODE_PORT_BITS-1:0]  req_dst_node,
   input  logic [mmt_pkg::SIZE_BITS-1:0]       req_byte_count,
   input  logic [mmt_pkg::DATA_BITS-1:0]       req_entry_data,
   output logic                                rsp_strobe,
   output logic [mmt_pkg::STATUS_BITS-1:0]     rsp_status,
   output logic                                rsp_hit,
   output logic                                rsp_hit_is_send,
   output logic [mmt_pkg::DATA_BITS-1:0]       rsp_popped_data
);

   localparam int KEY_NODE_BITS = (NODE_ID_BITS < mmt_pkg::NODE_PORT_BITS) ?
                                  NODE_ID_BITS : mmt_pkg::NODE_PORT_BITS;
   localparam int ROUTE_BITS    = mmt_pkg::TAG_BITS + 2 * KEY_NODE_BITS;

   mmt_pkg::mmt_state_type          state_ff, state_in;
   logic                            go_ff;
   logic [mmt_pkg::FUNC_BITS-1:0]   func_ff;
   logic [ROUTE_BITS-1:0]           route_ff;
   logic [mmt_pkg::SIZE_BITS-1:0]   size_ff;
   logic [mmt_pkg::DATA_BITS-1:0]   data_ff;
   logic                            accept;
   logic                            finish;
   mmt_pkg::mmt_chain_type          chain_w [TABLE_DEPTH+1];
   mmt_pkg::mmt_chain_type          last;
   mmt_pkg::mmt_commit_type         commit;
   logic [TABLE_DEPTH:0]            token_vec;

   logic                            rsp_strobe_ff;
   logic [mmt_pkg::STATUS_BITS-1:0] rsp_status_ff, rsp_status_in;
   logic                            rsp_hit_ff;
   logic                            rsp_hit_is_send_ff;
   logic [mmt_pkg::DATA_BITS-1:0]   rsp_popped_data_ff, rsp_popped_data_in;

   assign accept = start && (state_ff == mmt_pkg::MMT_IDLE);
   assign busy   = (state_ff != mmt_pkg::MMT_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= mmt_pkg::MMT_IDLE;
         go_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         go_ff    <= accept;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         func_ff  <= req_func;
         route_ff <= {req_msg_tag, req_src_node[KEY_NODE_BITS-1:0],
                      req_dst_node[KEY_NODE_BITS-1:0]};
         size_ff  <= req_byte_count;
         data_ff  <= req_entry_data;
      end
   end

   // the scan record leaves the last cell with hit and free information
   assign last   = chain_w[TABLE_DEPTH];
   assign finish = (state_ff == mmt_pkg::MMT_SCAN) && last.token;

   always_comb begin
      state_in           = state_ff;
      commit             = '0;
      commit.is_send     = (func_ff == mmt_pkg::FUNC_INS_SEND);
      rsp_status_in      = mmt_pkg::STAT_OK;
      rsp_popped_data_in = '0;
      case (state_ff)
         mmt_pkg::MMT_IDLE: begin
            if (start) begin
               state_in = mmt_pkg::MMT_SCAN;
            end
         end
         mmt_pkg::MMT_SCAN: begin
            if (last.token) begin
               state_in = mmt_pkg::MMT_IDLE;
            end
         end
         default: begin
            state_in = mmt_pkg::MMT_IDLE;
         end
      endcase

      case (func_ff)
         mmt_pkg::FUNC_INS_SEND, mmt_pkg::FUNC_INS_RECV: begin
            if (last.hit) begin
               rsp_status_in = mmt_pkg::STAT_DUPLICATE;
            end else if (!last.free_seen) begin
               rsp_status_in = mmt_pkg::STAT_FULL;
            end else begin
               commit.do_insert = finish;
            end
         end
         mmt_pkg::FUNC_POP_SEND, mmt_pkg::FUNC_POP_RECV: begin
            if (!last.hit) begin
               rsp_status_in = mmt_pkg::STAT_NOT_FOUND;
            end else if (last.hit_send != (func_ff == mmt_pkg::FUNC_POP_SEND)) begin
               rsp_status_in = mmt_pkg::STAT_MISMATCH;
            end else begin
               commit.do_pop      = finish;
               rsp_popped_data_in = last.payload;
            end
         end
         default: begin
            rsp_status_in = last.hit ? mmt_pkg::STAT_OK : mmt_pkg::STAT_NOT_FOUND;
         end
      endcase
   end

   assign chain_w[0] = '{token: go_ff, default: '0};

   genvar gi;
   generate
      for (gi = 0; gi < TABLE_DEPTH; gi++) begin : g_cell
         mmt_cell #(
            .ROUTE_BITS (ROUTE_BITS)
         ) u_cell (
            .clock     (clock),
            .reset     (reset),
            .req_route (route_ff),
            .req_size  (size_ff),
            .req_data  (data_ff),
            .commit    (commit),
            .chain_in  (chain_w[gi]),
            .chain_out (chain_w[gi+1])
         );
      end
      for (gi = 0; gi <= TABLE_DEPTH; gi++) begin : g_token
         assign token_vec[gi] = chain_w[gi].token;
      end
   endgenerate

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= finish;
      end
   end

   always_ff @(posedge clock) begin
      if (finish) begin
         rsp_status_ff      <= rsp_status_in;
         rsp_hit_ff         <= last.hit;
         rsp_hit_is_send_ff <= last.hit_send;
         rsp_popped_data_ff <= rsp_popped_data_in;
      end
   end

   assign rsp_strobe      = rsp_strobe_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_hit         = rsp_hit_ff;
   assign rsp_hit_is_send = rsp_hit_is_send_ff;
   assign rsp_popped_data = rsp_popped_data_ff;

`ifndef SYNTHESIS
   // one item at a time: at most one scan token anywhere in the row
   a_single_token: assert property (@(posedge clock) disable iff (reset)
      $onehot0(token_vec))
      else $error("more than one scan token in the cell row");

   a_rsp_after_scan: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> !busy && $past(busy))
      else $error("response without a finished scan");

   a_commit_exclusive: assert property (@(posedge clock) disable iff (reset)
      (commit.do_insert || commit.do_pop) |-> finish && !(commit.do_insert && commit.do_pop))
      else $error("table commit outside the closing cycle of a scan");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy && go_ff)
      else $error("accepted item did not start a scan");
`endif

endmodule

// File: tb/tb_message_match_table_unit.sv
// ============================================================================
// tb_message_match_table_unit
// Self-checking bench for the message match table. A queue of requests feeds
// a clocked driver; every accepted request runs through a local table model
// and its predicted response is compared field by field with the DUT output.
// ============================================================================
`timescale 1ns / 1ps

module tb_message_match_table_unit;

   localparam int TABLE_DEPTH  = 64;
   localparam int NODE_ID_BITS = 10;
   localparam int ROUTE_BITS   = mmt_pkg::TAG_BITS + 2 * mmt_pkg::NODE_PORT_BITS;
   localparam int MAX_REPORTS  = 10;

   // codes above POP_RECV are treated as a lookup
   localparam logic [mmt_pkg::FUNC_BITS-1:0] FUNC_SPARE_LO  = 3'd5;
   localparam logic [mmt_pkg::FUNC_BITS-1:0] FUNC_SPARE_MID = 3'd6;
   localparam logic [mmt_pkg::FUNC_BITS-1:0] FUNC_SPARE_HI  = 3'd7;

   localparam logic [mmt_pkg::NODE_PORT_BITS-1:0] NODE_MASK =
      mmt_pkg::NODE_PORT_BITS'((1 << NODE_ID_BITS) - 1);

   typedef struct packed {
      logic [mmt_pkg::TAG_BITS-1:0]       tag;
      logic [mmt_pkg::NODE_PORT_BITS-1:0] src;
      logic [mmt_pkg::NODE_PORT_BITS-1:0] dst;
      logic [mmt_pkg::SIZE_BITS-1:0]      size;
   } msg_key_type;

   typedef struct packed {
      logic [mmt_pkg::FUNC_BITS-1:0] func;
      msg_key_type                   key;
      logic [mmt_pkg::DATA_BITS-1:0] data;
   } msg_req_type;

   typedef struct packed {
      logic [mmt_pkg::STATUS_BITS-1:0] status;
      logic                            hit;
      logic                            hit_send;
      logic [mmt_pkg::DATA_BITS-1:0]   popped;
   } msg_rsp_type;

   // drain entries hold the sender until every response is back
   typedef struct {
      msg_req_type req;
      int          idle_pct;
      bit          drain;
   } queued_req_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                                start          = 1'b0;
   logic                                busy;
   logic [mmt_pkg::FUNC_BITS-1:0]       req_func       = '0;
   logic [mmt_pkg::TAG_BITS-1:0]        req_msg_tag    = '0;
   logic [mmt_pkg::NODE_PORT_BITS-1:0]  req_src_node   = '0;
   logic [mmt_pkg::NODE_PORT_BITS-1:0]  req_dst_node   = '0;
   logic [mmt_pkg::SIZE_BITS-1:0]       req_byte_count = '0;
   logic [mmt_pkg::DATA_BITS-1:0]       req_entry_data = '0;
   logic                                rsp_strobe;
   logic [mmt_pkg::STATUS_BITS-1:0]     rsp_status;
   logic                                rsp_hit;
   logic                                rsp_hit_is_send;
   logic [mmt_pkg::DATA_BITS-1:0]       rsp_popped_data;

   message_match_table_unit #(
      .TABLE_DEPTH  (TABLE_DEPTH),
      .NODE_ID_BITS (NODE_ID_BITS)
   ) i_dut (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_func        (req_func),
      .req_msg_tag     (req_msg_tag),
      .req_src_node    (req_src_node),
      .req_dst_node    (req_dst_node),
      .req_byte_count  (req_byte_count),
      .req_entry_data  (req_entry_data),
      .rsp_strobe      (rsp_strobe),
      .rsp_status      (rsp_status),
      .rsp_hit         (rsp_hit),
      .rsp_hit_is_send (rsp_hit_is_send),
      .rsp_popped_data (rsp_popped_data)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // ------------------------------------------------------------------
   // table model
   // ------------------------------------------------------------------
   bit                             slot_used    [TABLE_DEPTH];
   bit                             slot_send    [TABLE_DEPTH];
   logic [ROUTE_BITS-1:0]          slot_route   [TABLE_DEPTH];
   logic [mmt_pkg::SIZE_BITS-1:0]  slot_size    [TABLE_DEPTH];
   logic [mmt_pkg::DATA_BITS-1:0]  slot_payload [TABLE_DEPTH];

   queued_req_type pending_reqs[$];
   msg_rsp_type    pending_rsps[$];
   int             fail_count = 0;
   int             rsp_count  = 0;

   function automatic msg_rsp_type table_apply(msg_req_type r);
      logic [ROUTE_BITS-1:0] route;
      msg_rsp_type           rsp;
      int                    match_idx;
      int                    free_idx;
      bit                    want_send;
      route     = {r.key.tag, r.key.src & NODE_MASK, r.key.dst & NODE_MASK};
      rsp       = '0;
      match_idx = -1;
      free_idx  = -1;
      for (int i = TABLE_DEPTH - 1; i >= 0; i--) begin
         if (slot_used[i] && slot_route[i] == route && slot_size[i] == r.key.size)
            match_idx = i;
         if (!slot_used[i])
            free_idx = i;
      end
      if (match_idx >= 0) begin
         rsp.hit      = 1'b1;
         rsp.hit_send = slot_send[match_idx];
      end
      case (r.func)
         mmt_pkg::FUNC_INS_SEND, mmt_pkg::FUNC_INS_RECV: begin
            if (match_idx >= 0)
               rsp.status = mmt_pkg::STAT_DUPLICATE;
            else if (free_idx < 0)
               rsp.status = mmt_pkg::STAT_FULL;
            else begin
               rsp.status             = mmt_pkg::STAT_OK;
               slot_used[free_idx]    = 1'b1;
               slot_send[free_idx]    = (r.func == mmt_pkg::FUNC_INS_SEND);
               slot_route[free_idx]   = route;
               slot_size[free_idx]    = r.key.size;
               slot_payload[free_idx] = r.data;
            end
         end
         mmt_pkg::FUNC_POP_SEND, mmt_pkg::FUNC_POP_RECV: begin
            want_send = (r.func == mmt_pkg::FUNC_POP_SEND);
            if (match_idx < 0)
               rsp.status = mmt_pkg::STAT_NOT_FOUND;
            else if (slot_send[match_idx] != want_send)
               rsp.status = mmt_pkg::STAT_MISMATCH;
            else begin
               rsp.status           = mmt_pkg::STAT_OK;
               rsp.popped           = slot_payload[match_idx];
               slot_used[match_idx] = 1'b0;
            end
         end
         default: rsp.status = (match_idx >= 0) ? mmt_pkg::STAT_OK : mmt_pkg::STAT_NOT_FOUND;
      endcase
      return rsp;
   endfunction

   // ------------------------------------------------------------------
   // driver
   // ------------------------------------------------------------------
   bit          req_taken;
   bit          req_present;
   msg_req_type head_req;

   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else begin
         req_taken   = start && !busy;
         req_present = 1'b0;
         if (req_taken) begin
            pending_rsps.push_back(table_apply(pending_reqs[0].req));
            void'(pending_reqs.pop_front());
         end
         if (pending_reqs.size() > 0) begin
            if (pending_reqs[0].drain) begin
               if (!req_taken && pending_rsps.size() == 0)
                  void'(pending_reqs.pop_front());
            end else if ($urandom_range(99) >= pending_reqs[0].idle_pct) begin
               req_present = 1'b1;
               head_req    = pending_reqs[0].req;
               req_func       <= head_req.func;
               req_msg_tag    <= head_req.key.tag;
               req_src_node   <= head_req.key.src;
               req_dst_node   <= head_req.key.dst;
               req_byte_count <= head_req.key.size;
               req_entry_data <= head_req.data;
            end
         end
         start <= req_present;
      end
   end

   // ------------------------------------------------------------------
   // monitor
   // ------------------------------------------------------------------
   msg_rsp_type want_rsp;

   always @(posedge clock) begin
      if (!reset && rsp_strobe) begin
         rsp_count <= rsp_count + 1;
         if (pending_rsps.size() == 0) begin
            if (fail_count < MAX_REPORTS)
               $display("response %0d with nothing outstanding: status %0d", rsp_count,
                        rsp_status);
            fail_count <= fail_count + 1;
         end else begin
            want_rsp = pending_rsps.pop_front();
            if (rsp_status !== want_rsp.status || rsp_hit !== want_rsp.hit ||
                rsp_hit_is_send !== want_rsp.hit_send ||
                rsp_popped_data !== want_rsp.popped) begin
               if (fail_count < MAX_REPORTS) begin
                  $write("response %0d: got status %0d hit %b send %b data %h, ",
                         rsp_count, rsp_status, rsp_hit, rsp_hit_is_send,
                         rsp_popped_data);
                  $display("want status %0d hit %b send %b data %h",
                           want_rsp.status, want_rsp.hit, want_rsp.hit_send,
                           want_rsp.popped);
               end
               fail_count <= fail_count + 1;
            end
         end
      end
   end

   // ------------------------------------------------------------------
   // stimulus
   // ------------------------------------------------------------------
   task automatic add_req(logic [mmt_pkg::FUNC_BITS-1:0] func, msg_key_type key,
                          logic [mmt_pkg::DATA_BITS-1:0] data, int idle_pct);
      queued_req_type q;
      q.req      = '{func: func, key: key, data: data};
      q.idle_pct = idle_pct;
      q.drain    = 1'b0;
      pending_reqs.push_back(q);
   endtask

   task automatic add_drain();
      queued_req_type q;
      q.req      = '0;
      q.idle_pct = 0;
      q.drain    = 1'b1;
      pending_reqs.push_back(q);
   endtask

   function automatic msg_key_type random_key();
      msg_key_type k;
      k.tag  = mmt_pkg::TAG_BITS'($urandom);
      k.src  = mmt_pkg::NODE_PORT_BITS'($urandom);
      k.dst  = mmt_pkg::NODE_PORT_BITS'($urandom);
      k.size = $urandom;
      return k;
   endfunction

   msg_key_type key_pool[96];

   // one phase of random traffic drawn from the first pool_size keys
   task automatic add_phase(int count, int ins_pct, int pop_pct, int pool_size,
                            int idle_pct);
      int                            pick;
      logic [mmt_pkg::FUNC_BITS-1:0] func;
      msg_key_type                   key;
      for (int n = 0; n < count; n++) begin
         pick = $urandom_range(99);
         if (pick < ins_pct)
            func = $urandom_range(1) ? mmt_pkg::FUNC_INS_SEND : mmt_pkg::FUNC_INS_RECV;
         else if (pick < ins_pct + pop_pct)
            func = $urandom_range(1) ? mmt_pkg::FUNC_POP_SEND : mmt_pkg::FUNC_POP_RECV;
         else if ($urandom_range(3) == 0)
            func = mmt_pkg::FUNC_BITS'($urandom_range(FUNC_SPARE_HI, FUNC_SPARE_LO));
         else
            func = mmt_pkg::FUNC_LOOKUP;
         // a few stray keys outside the pool
         key = ($urandom_range(19) == 0) ? random_key()
                                         : key_pool[$urandom_range(pool_size - 1)];
         add_req(func, key, {$urandom, $urandom}, idle_pct);
      end
   endtask

   initial begin
      msg_key_type key_max;
      msg_key_type key_zero;
      msg_key_type key_near;
      msg_key_type key_other;

      key_max   = '1;
      key_zero  = '0;
      key_near  = '0;
      key_near.size = 32'd1;
      key_other = '{tag: 16'h8001, src: 10'h200, dst: 10'h155, size: 32'h8000_0000};

      // edge cases on an empty table, then a short walk through every code
      add_req(mmt_pkg::FUNC_LOOKUP,   key_max,   '0,                      0);
      add_req(mmt_pkg::FUNC_POP_SEND, key_max,   '1,                      0);
      add_req(mmt_pkg::FUNC_INS_SEND, key_max,   '1,                      0);
      add_req(mmt_pkg::FUNC_INS_SEND, key_max,   64'h1,                   0);
      add_req(mmt_pkg::FUNC_INS_RECV, key_max,   64'h2,                   0);
      add_req(mmt_pkg::FUNC_LOOKUP,   key_max,   '0,                      0);
      add_req(mmt_pkg::FUNC_POP_RECV, key_max,   '0,                      0);
      add_req(FUNC_SPARE_LO,          key_max,   '0,                      0);
      add_req(FUNC_SPARE_HI,          key_zero,  '0,                      0);
      add_req(mmt_pkg::FUNC_INS_RECV, key_zero,  '0,                      0);
      add_req(mmt_pkg::FUNC_INS_RECV, key_near,  64'h0123_4567_89ab_cdef, 0);
      add_req(mmt_pkg::FUNC_POP_SEND, key_zero,  '0,                      0);
      add_req(mmt_pkg::FUNC_POP_SEND, key_max,   '0,                      0);
      // slot 0 is free again, so the next insert lands there
      add_req(mmt_pkg::FUNC_INS_SEND, key_other, 64'h8000_0000_0000_0001, 0);
      add_req(mmt_pkg::FUNC_POP_RECV, key_zero,  '1,                      0);
      add_req(mmt_pkg::FUNC_LOOKUP,   key_zero,  '0,                      0);
      add_req(mmt_pkg::FUNC_POP_RECV, key_near,  '0,                      0);
      add_req(FUNC_SPARE_MID,         key_other, '0,                      0);
      add_req(mmt_pkg::FUNC_POP_RECV, key_other, '0,                      0);
      add_req(mmt_pkg::FUNC_POP_SEND, key_other, '0,                      0);
      add_drain();

      // pool has near neighbors: keys that differ from another in one field
      foreach (key_pool[i]) begin
         key_pool[i] = random_key();
         if (i > 0 && $urandom_range(2) == 0) begin
            key_pool[i] = key_pool[i - 1];
            case ($urandom_range(3))
               0: key_pool[i].tag  = mmt_pkg::TAG_BITS'($urandom);
               1: key_pool[i].src  = mmt_pkg::NODE_PORT_BITS'($urandom);
               2: key_pool[i].dst  = mmt_pkg::NODE_PORT_BITS'($urandom);
               default: key_pool[i].size = $urandom;
            endcase
         end
      end

      add_phase(200, 40, 40, 12, 0);
      add_phase(200, 80, 5,  96, 68);   // fills the table and runs into full
      add_drain();
      add_phase(200, 10, 80, 96, 20);   // mostly pops, empties it again
      add_phase(200, 45, 40, 40, 68);
      add_drain();
      add_phase(200, 60, 30, 80, 0);

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      while (pending_reqs.size() != 0 || start || pending_rsps.size() != 0)
         @(posedge clock);
      repeat (TABLE_DEPTH + 4) @(posedge clock);

      if (fail_count == 0 && pending_rsps.size() == 0)
         $display("message_match_table_unit: match");
      else
         $display("message_match_table_unit: mismatch");
      $finish;
   end

   initial begin
      #3_000_000;
      $display("message_match_table_unit: mismatch");
      $finish;
   end

endmodule
